FILE: rtl/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

   localparam int RAW_W     = 24;
   localparam int CAL_W     = 16;
   localparam int TEMP_W    = 19;
   localparam int PRESS_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_STAGES = 9;

   // Internal datapath widths, sized from the value ranges of the compensation.
   localparam int DT_W    = 25;
   localparam int BASE_W  = 36;
   localparam int SQ_W    = 36;
   localparam int CORR_W  = 40;
   localparam int SPLIT_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_SENSITIVITY   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_OFFSET        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY_TEMP_COEFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_TEMP_COEFF      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_TEMPERATURE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPERATURE_COEFF      = 3'd5;

   localparam logic signed [19:0] TEMP_REF      = 20'sd2000;
   localparam logic signed [19:0] TEMP_LOW_DIST = 20'sd3500;

   typedef struct packed {
      logic [CAL_W-1:0] pressure_sensitivity;
      logic [CAL_W-1:0] pressure_offset;
      logic [CAL_W-1:0] sensitivity_temp_coeff;
      logic [CAL_W-1:0] offset_temp_coeff;
      logic [CAL_W-1:0] reference_temperature;
      logic [CAL_W-1:0] temperature_coeff;
   } cal_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp_c;
      logic signed [BASE_W-1:0] off;
      logic signed [BASE_W-1:0] sens;
      logic [SQ_W-1:0]          sq;
      logic [SQ_W-1:0]          sq2;
      logic                     lt_ref;
      logic                     lt_low;
   } thermal_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp_c;
      logic signed [CORR_W-1:0] off_c;
      logic signed [CORR_W-1:0] sens_c;
   } corr_type;

endpackage
`default_nettype wire

FILE: rtl/bpc_thermal.sv
`default_nettype none
module bpc_thermal
   import bpc_pkg::*;
(
   input  wire logic             clock,
   input  wire cal_type          cal,
   input  wire logic [3:0]       en,
   input  wire logic [RAW_W-1:0] d1,
   input  wire logic [RAW_W-1:0] d2,
   output thermal_type           th
);

   // Stage 0: temperature difference.
   logic [RAW_W-1:0]       d1_s0_ff;
   logic signed [DT_W-1:0] dt_ff;
   logic signed [DT_W-1:0] dt_in;

   // Stage 1: products of dT.
   logic [RAW_W-1:0]   d1_s1_ff;
   logic signed [41:0] pt_ff, po_ff, ps_ff;
   logic signed [41:0] pt_in, po_in, ps_in;
   logic signed [49:0] dsq_ff, dsq_in;

   // Stage 2: first-order terms.
   logic [RAW_W-1:0]         d1_s2_ff;
   logic signed [19:0]       temp_s2_ff, temp_s2_in;
   logic [17:0]              t2_ff;
   logic signed [BASE_W-1:0] off_s2_ff, off_s2_in;
   logic signed [BASE_W-1:0] sens_s2_ff, sens_s2_in;
   logic signed [TEMP_W-1:0] d_ff, tq;
   logic signed [19:0]       e_ff, e_in;

   // Stage 3: squares of the temperature distances.
   thermal_type        th_ff, th_in;
   logic signed [37:0] sq_full;
   logic signed [39:0] sq2_full;
   logic signed [19:0] temp_fin;

   assign dt_in = $signed({1'b0, d2}) - $signed({1'b0, cal.reference_temperature, 8'b0});

   assign pt_in  = dt_ff * $signed({1'b0, cal.temperature_coeff});
   assign po_in  = dt_ff * $signed({1'b0, cal.offset_temp_coeff});
   assign ps_in  = dt_ff * $signed({1'b0, cal.sensitivity_temp_coeff});
   assign dsq_in = dt_ff * dt_ff;

   assign tq         = pt_ff[41:23];
   assign temp_s2_in = $signed({tq[TEMP_W-1], tq}) + TEMP_REF;
   assign e_in       = $signed({tq[TEMP_W-1], tq}) + TEMP_LOW_DIST;
   assign off_s2_in  = $signed({4'b0, cal.pressure_offset, 16'b0}) + $signed(po_ff[41:7]);
   assign sens_s2_in = $signed({5'b0, cal.pressure_sensitivity, 15'b0})
                     + $signed(ps_ff[41:8]);

   assign sq_full  = d_ff * d_ff;
   assign sq2_full = e_ff * e_ff;

   // The dT squared term only applies below the reference temperature.
   assign temp_fin = d_ff[TEMP_W-1] ? (temp_s2_ff - $signed({2'b0, t2_ff})) : temp_s2_ff;

   always_comb begin
      th_in        = th_ff;
      th_in.d1     = d1_s2_ff;
      th_in.temp_c = temp_fin[TEMP_W-1:0];
      th_in.off    = off_s2_ff;
      th_in.sens   = sens_s2_ff;
      th_in.sq     = sq_full[SQ_W-1:0];
      th_in.sq2    = sq2_full[SQ_W-1:0];
      th_in.lt_ref = d_ff[TEMP_W-1];
      th_in.lt_low = e_ff[19];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d1_s0_ff <= d1;
         dt_ff    <= dt_in;
      end
      if (en[1]) begin
         d1_s1_ff <= d1_s0_ff;
         pt_ff    <= pt_in;
         po_ff    <= po_in;
         ps_ff    <= ps_in;
         dsq_ff   <= dsq_in;
      end
      if (en[2]) begin
         d1_s2_ff   <= d1_s1_ff;
         temp_s2_ff <= temp_s2_in;
         t2_ff      <= dsq_ff[48:31];
         off_s2_ff  <= off_s2_in;
         sens_s2_ff <= sens_s2_in;
         d_ff       <= tq;
         e_ff       <= e_in;
      end
      if (en[3]) begin
         th_ff <= th_in;
      end
   end

   assign th = th_ff;

endmodule
`default_nettype wire

FILE: rtl/bpc_corr.sv
`default_nettype none
module bpc_corr
   import bpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [1:0]  en,
   input  wire thermal_type th,
   output corr_type         co
);

   logic [RAW_W-1:0]         d1_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic signed [BASE_W-1:0] off_ff, sens_ff;
   logic [CORR_W-1:0]        off2_ff, off2_in;
   logic [CORR_W-1:0]        sens2_ff, sens2_in;
   logic [CORR_W-1:0]        sq_h, sq_q, sq2_w, sq2_h;
   logic [CORR_W-1:0]        off_low, sens_low;
   corr_type                 co_ff, co_in;

   assign sq_h  = {5'b0, th.sq[SQ_W-1:1]};
   assign sq_q  = {6'b0, th.sq[SQ_W-1:2]};
   assign sq2_w = {4'b0, th.sq2};
   assign sq2_h = {5'b0, th.sq2[SQ_W-1:1]};

   // Constant factors 5, 7 and 11 are formed by shift and add, 7 as eight times less one.
   assign off_low  = th.lt_low ? ({sq2_w[CORR_W-4:0], 3'b0} - sq2_w) : '0;
   assign sens_low = th.lt_low ? ({sq2_h[CORR_W-4:0], 3'b0} + {sq2_h[CORR_W-2:0], 1'b0}
                                  + sq2_h) : '0;

   assign off2_in  = th.lt_ref ? ({sq_h[CORR_W-3:0], 2'b0} + sq_h + off_low) : '0;
   assign sens2_in = th.lt_ref ? ({sq_q[CORR_W-3:0], 2'b0} + sq_q + sens_low) : '0;

   always_comb begin
      co_in        = co_ff;
      co_in.d1     = d1_ff;
      co_in.temp_c = temp_ff;
      co_in.off_c  = $signed({{(CORR_W-BASE_W){off_ff[BASE_W-1]}}, off_ff})
                   - $signed(off2_ff);
      co_in.sens_c = $signed({{(CORR_W-BASE_W){sens_ff[BASE_W-1]}}, sens_ff})
                   - $signed(sens2_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d1_ff    <= th.d1;
         temp_ff  <= th.temp_c;
         off_ff   <= th.off;
         sens_ff  <= th.sens;
         off2_ff  <= off2_in;
         sens2_ff <= sens2_in;
      end
      if (en[1]) begin
         co_ff <= co_in;
      end
   end

   assign co = co_ff;

endmodule
`default_nettype wire

FILE: rtl/bpc_press.sv
`default_nettype none
module bpc_press
   import bpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [2:0]         en,
   input  wire corr_type           co,
   output logic signed [TEMP_W-1:0]  temperature_centi,
   output logic signed [PRESS_W-1:0] pressure_pa
);

   // The 24 by 40 bit sensitivity product is split into two halves.
   logic [43:0]              pp_lo_ff, pp_lo_in;
   logic signed [44:0]       pp_hi_ff, pp_hi_in;
   logic signed [CORR_W-1:0] off_s6_ff, off_s7_ff;
   logic signed [TEMP_W-1:0] temp_s6_ff, temp_s7_ff, temp_ff;
   logic [63:0]              prod_ff, prod_in;
   logic signed [43:0]       q;
   logic signed [PRESS_W-1:0] press_ff;

   assign pp_lo_in = co.d1 * co.sens_c[SPLIT_W-1:0];
   assign pp_hi_in = $signed({1'b0, co.d1}) * $signed(co.sens_c[CORR_W-1:SPLIT_W]);
   assign prod_in  = {pp_hi_ff[43:0], 20'b0} + {20'b0, pp_lo_ff};

   assign q = $signed({prod_ff[63], prod_ff[63:21]})
            - $signed({{4{off_s7_ff[CORR_W-1]}}, off_s7_ff});

   // The result never needs more than 29 bits, so saturation reduces to sign extension.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pp_lo_ff   <= pp_lo_in;
         pp_hi_ff   <= pp_hi_in;
         off_s6_ff  <= co.off_c;
         temp_s6_ff <= co.temp_c;
      end
      if (en[1]) begin
         prod_ff    <= prod_in;
         off_s7_ff  <= off_s6_ff;
         temp_s7_ff <= temp_s6_ff;
      end
      if (en[2]) begin
         press_ff <= {{3{q[43]}}, q[43:15]};
         temp_ff  <= temp_s7_ff;
      end
   end

   assign temperature_centi = temp_ff;
   assign pressure_pa       = press_ff;

endmodule
`default_nettype wire

FILE: rtl/barometric_pressure_compensation.sv
`default_nettype none
// Second-order temperature-compensated barometer datapath. Each req beat carries one raw
// pressure and one raw temperature conversion; the matching rsp beat gives the temperature
// in hundredths of a degree and the pressure in pascals. The nine register stages are set
// by the chain of registered multipliers: the dT products, the squares for the
// low-temperature correction and the split 24 by 40 bit sensitivity product. One beat
// is accepted every cycle unless a stall on rsp holds back req; each stage holds its own
// valid bit, so a stall on rsp fills empty stages first and only then holds back req. The
// six calibration words are written through the csr port, are zero after reset, and
// should be changed only while no beat is in flight.
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [47:0]          req_tdata,  // pressure_raw[23:0], temperature_raw[47:24]
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [55:0]               rsp_tdata,  // temperature_centi[18:0], pressure_pa[50:19]
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CAL_W-1:0]     csr_data
);

   cal_type                   cal_ff;
   logic [NUM_STAGES-1:0]     valid_ff, valid_in;
   logic [NUM_STAGES-1:0]     en;
   thermal_type               th;
   corr_type                  co;
   logic signed [TEMP_W-1:0]  temperature_centi;
   logic signed [PRESS_W-1:0] pressure_pa;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESSURE_SENSITIVITY:   cal_ff.pressure_sensitivity   <= csr_data;
            CSR_PRESSURE_OFFSET:        cal_ff.pressure_offset        <= csr_data;
            CSR_SENSITIVITY_TEMP_COEFF: cal_ff.sensitivity_temp_coeff <= csr_data;
            CSR_OFFSET_TEMP_COEFF:      cal_ff.offset_temp_coeff      <= csr_data;
            CSR_REFERENCE_TEMPERATURE:  cal_ff.reference_temperature  <= csr_data;
            CSR_TEMPERATURE_COEFF:      cal_ff.temperature_coeff      <= csr_data;
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or when the stage after it loads this cycle.
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (en[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {5'b0, pressure_pa, temperature_centi};

   bpc_thermal u_thermal (
      .clock (clock),
      .cal   (cal_ff),
      .en    (en[3:0]),
      .d1    (req_tdata[23:0]),
      .d2    (req_tdata[47:24]),
      .th    (th)
   );

   bpc_corr u_corr (
      .clock (clock),
      .en    (en[5:4]),
      .th    (th),
      .co    (co)
   );

   bpc_press u_press (
      .clock             (clock),
      .en                (en[8:6]),
      .co                (co),
      .temperature_centi (temperature_centi),
      .pressure_pa       (pressure_pa)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (temperature_centi >= -19'sd260144) && (temperature_centi <= 19'sd133071))
      else $error("compensated temperature out of range");

   a_press_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pressure_pa[31:28] == 4'h0) || (pressure_pa[31:28] == 4'hF))
      else $error("pressure exceeds the 29-bit range of the datapath");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0) |-> req_tready)
      else $error("empty pipeline refuses input");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;
   localparam logic [RAW_W-1:0]     RAW_MAX       = '1;
   localparam logic [CAL_W-1:0]     CAL_MAX       = '1;
   localparam longint WARM_LIMIT = 2000;
   localparam longint COLD_LIMIT = -1500;
   localparam longint PRESS_MAX  = 2147483647;
   localparam longint PRESS_MIN  = -PRESS_MAX - 1;
   localparam int     RANDOM_PHASES    = 10;
   localparam int     ITEMS_PER_PHASE  = 48;

   typedef struct packed {
      logic signed [TEMP_W-1:0]  temperature_centi;
      logic signed [PRESS_W-1:0] pressure_pa;
   } compensated_type;

   typedef struct {
      int                        preset;
      logic [RAW_W-1:0]          d1;
      logic [RAW_W-1:0]          d2;
      bit                        typed;
      logic signed [TEMP_W-1:0]  temperature;
      logic signed [PRESS_W-1:0] pressure;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [47:0]          req_tdata = '0;   // pressure_raw[23:0], temperature_raw[47:24]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [55:0]          rsp_tdata;        // temperature_centi[18:0], pressure_pa[50:19]
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CAL_W-1:0]     csr_data = '0;

   logic signed [TEMP_W-1:0]  rsp_temperature;
   logic signed [PRESS_W-1:0] rsp_pressure;

   cal_type         calibration = '0;
   compensated_type pending_readings[$];
   int unsigned     mismatch_count = 0;
   bit              quiet = 1'b0;
   int              rsp_hold_cycles = 0;

   // Calibration sets for the directed part; set 0 is the state after reset.
   cal_type presets[5] = '{
      '0,
      '{pressure_sensitivity: 16'd40127, pressure_offset: 16'd36924,
        sensitivity_temp_coeff: 16'd23317, offset_temp_coeff: 16'd23282,
        reference_temperature: 16'd33464, temperature_coeff: 16'd28312},
      '{pressure_sensitivity: 16'hFFFF, pressure_offset: 16'd0,
        sensitivity_temp_coeff: 16'hFFFF, offset_temp_coeff: 16'd0,
        reference_temperature: 16'd8000, temperature_coeff: 16'd32768},
      '1,
      '0
   };

   // With calibration set 2 the temperature is 2000 + (dT >> 8) and dT = D2 - 2048000,
   // so the rows walk across the second-order and the extra low-temperature thresholds.
   directed_row_type directed[22] = '{
      '{0, 24'h000000, 24'h000000, 1'b1, 19'sd2000, 32'sd0},
      '{0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 19'sd2000, 32'sd0},
      '{0, 24'hFFFFFF, 24'h000000, 1'b1, 19'sd2000, 32'sd0},
      '{0, 24'h000000, 24'hFFFFFF, 1'b1, 19'sd2000, 32'sd0},
      '{0, 24'hAAAAAA, 24'h555555, 1'b1, 19'sd2000, 32'sd0},
      '{1, 24'd9085466, 24'd8569150, 1'b0, 19'sd0, 32'sd0},
      '{1, 24'h000000, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'sd0, 32'sd0},
      '{1, 24'hFFFFFF, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{2, 24'hFFFFFF, 24'd2048000, 1'b0, 19'sd0, 32'sd0},
      '{2, 24'hFFFFFF, 24'd2047999, 1'b0, 19'sd0, 32'sd0},
      '{2, 24'hFFFFFF, 24'd1792000, 1'b0, 19'sd0, 32'sd0},
      '{2, 24'hFFFFFF, 24'd1152000, 1'b0, 19'sd0, 32'sd0},
      '{2, 24'hFFFFFF, 24'd1151999, 1'b0, 19'sd0, 32'sd0},
      '{2, 24'hFFFFFF, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'sd0, 32'sd0},
      '{3, 24'hFFFFFF, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{3, 24'h000000, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{3, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'sd0, 32'sd0},
      '{3, 24'h123456, 24'h800000, 1'b0, 19'sd0, 32'sd0},
      '{4, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 19'sd2000, 32'sd0},
      '{4, 24'hFFFFFF, 24'h000000, 1'b1, 19'sd2000, 32'sd0}
   };

   assign rsp_temperature = rsp_tdata[18:0];
   assign rsp_pressure    = rsp_tdata[50:19];

   barometric_pressure_compensation DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Second-order compensation in 64-bit signed arithmetic; >>> is a floor shift.
   function automatic compensated_type compensate(cal_type c, logic [RAW_W-1:0] d1,
                                                  logic [RAW_W-1:0] d2);
      longint          dt, temp, off, sens, t2, off2, sens2, sq, sq2, p;
      compensated_type r;
      dt   = longint'(d2) - (longint'(c.reference_temperature) <<< 8);
      temp = WARM_LIMIT + ((dt * longint'(c.temperature_coeff)) >>> 23);
      off  = (longint'(c.pressure_offset) <<< 16)
           + ((longint'(c.offset_temp_coeff) * dt) >>> 7);
      sens = (longint'(c.pressure_sensitivity) <<< 15)
           + ((longint'(c.sensitivity_temp_coeff) * dt) >>> 8);
      t2    = 0;
      off2  = 0;
      sens2 = 0;
      if (temp < WARM_LIMIT) begin
         sq    = (temp - WARM_LIMIT) * (temp - WARM_LIMIT);
         t2    = (dt * dt) >>> 31;
         off2  = 5 * (sq >>> 1);
         sens2 = 5 * (sq >>> 2);
         if (temp < COLD_LIMIT) begin
            sq2    = (temp - COLD_LIMIT) * (temp - COLD_LIMIT);
            off2  += 7 * sq2;
            sens2 += 11 * (sq2 >>> 1);
         end
      end
      p = (((longint'(d1) * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
      if (p > PRESS_MAX) p = PRESS_MAX;
      if (p < PRESS_MIN) p = PRESS_MIN;
      r.temperature_centi = TEMP_W'(temp - t2);
      r.pressure_pa       = PRESS_W'(p);
      return r;
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [CAL_W-1:0] pick_cal_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return CAL_MAX;
         default: return CAL_W'($urandom);
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CAL_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PRESSURE_SENSITIVITY:   calibration.pressure_sensitivity   = value;
         CSR_PRESSURE_OFFSET:        calibration.pressure_offset        = value;
         CSR_SENSITIVITY_TEMP_COEFF: calibration.sensitivity_temp_coeff = value;
         CSR_OFFSET_TEMP_COEFF:      calibration.offset_temp_coeff      = value;
         CSR_REFERENCE_TEMPERATURE:  calibration.reference_temperature  = value;
         CSR_TEMPERATURE_COEFF:      calibration.temperature_coeff      = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // A write to one of the unused indexes follows, and must leave the words alone.
   task automatic load_calibration(cal_type c);
      write_reg(CSR_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
      write_reg(CSR_PRESSURE_OFFSET, c.pressure_offset);
      write_reg(CSR_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
      write_reg(CSR_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
      write_reg(CSR_REFERENCE_TEMPERATURE, c.reference_temperature);
      write_reg(CSR_TEMPERATURE_COEFF, c.temperature_coeff);
      write_reg($urandom_range(0, 1) ? CSR_UNUSED_HI : CSR_UNUSED_LO, CAL_W'($urandom));
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_reading(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2, bit typed,
                               compensated_type known);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {d2, d1};
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(typed ? known : compensate(calibration, d1, d2));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Output side: random stalls, plus a long hold-off when the stimulus asks for one.
   initial begin
      int stall_left;
      int g;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (quiet) begin
            rsp_tready = 1'b1;
         end else begin
            g = pick_gap();
            rsp_tready = (g == 0);
            stall_left = (g > 0) ? g - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      compensated_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("result beat with no reading outstanding");
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_temperature !== want.temperature_centi) begin
               $error("temperature_centi: expected %0d, got %0d",
                      want.temperature_centi, rsp_temperature);
               mismatch_count++;
            end
            if (rsp_pressure !== want.pressure_pa) begin
               $error("pressure_pa: expected %0d, got %0d", want.pressure_pa, rsp_pressure);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int               current;
      int               near;
      int               sel;
      cal_type          c;
      logic [RAW_W-1:0] d1;
      logic [RAW_W-1:0] d2;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      current = 0;
      foreach (directed[i]) begin
         if (directed[i].preset != current) begin
            wait_drained();
            current = directed[i].preset;
            load_calibration(presets[current]);
         end
         send_reading(directed[i].d1, directed[i].d2, directed[i].typed,
                      '{temperature_centi: directed[i].temperature,
                        pressure_pa: directed[i].pressure});
      end

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         wait_drained();
         quiet = 1'b0;
         case (k)
            3: c = '1;
            6: c = '0;
            8: c = presets[1];
            default: begin
               c.pressure_sensitivity   = pick_cal_word();
               c.pressure_offset        = pick_cal_word();
               c.sensitivity_temp_coeff = pick_cal_word();
               c.offset_temp_coeff      = pick_cal_word();
               c.reference_temperature  = pick_cal_word();
               c.temperature_coeff      = pick_cal_word();
            end
         endcase
         load_calibration(c);
         // Phase 2 holds the output side off long enough for the pipeline to back up.
         quiet = (k == 1 || k == 2 || k == 5);
         if (k == 2) rsp_hold_cycles = 120;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               0: d1 = '0;
               1: d1 = RAW_MAX;
               default: d1 = RAW_W'($urandom);
            endcase
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
               d2 = RAW_W'($urandom);
            end else if (sel < 8) begin
               // Close to the reference point, where the corrections switch in.
               near = int'(calibration.reference_temperature) * 256
                    + int'($urandom_range(0, 8192)) - 4096;
               if (near < 0) near = 0;
               if (near > int'(RAW_MAX)) near = int'(RAW_MAX);
               d2 = RAW_W'(near);
            end else if (sel < 9) begin
               d2 = '0;
            end else begin
               d2 = RAW_MAX;
            end
            send_reading(d1, d2, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (NUM_STAGES + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_readings.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
